@@ design/psm_pkg.sv @@
package psm_pkg;

    typedef enum logic [2:0] {
        OP_LIT = 3'd0,
        OP_OPR = 3'd1,
        OP_LOD = 3'd2,
        OP_STO = 3'd3,
        OP_CAL = 3'd4,
        OP_INT = 3'd5,
        OP_JMP = 3'd6,
        OP_JPC = 3'd7
    } opcode_t;

    localparam logic [15:0] OPR_RET = 16'd0;
    localparam logic [15:0] OPR_NEG = 16'd1;
    localparam logic [15:0] OPR_ADD = 16'd2;
    localparam logic [15:0] OPR_SUB = 16'd3;
    localparam logic [15:0] OPR_MUL = 16'd4;
    localparam logic [15:0] OPR_DIV = 16'd5;
    localparam logic [15:0] OPR_ODD = 16'd6;
    localparam logic [15:0] OPR_EQL = 16'd7;
    localparam logic [15:0] OPR_NEQ = 16'd8;
    localparam logic [15:0] OPR_LSS = 16'd9;
    localparam logic [15:0] OPR_GEQ = 16'd10;
    localparam logic [15:0] OPR_GTR = 16'd11;
    localparam logic [15:0] OPR_LEQ = 16'd12;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_DIV0  = 2'd1;
    localparam logic [1:0] FAULT_RANGE = 2'd2;

    // divider request and response
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

@@ design/psm_divider.sv @@
module psm_divider
    import psm_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  div_ctl_t              ctl,
    input  logic [WORD_WIDTH-1:0] dividend,
    input  logic [WORD_WIDTH-1:0] divisor,
    output div_sts_t              sts,
    output logic [WORD_WIDTH-1:0] quotient
);
    localparam int CW = $clog2(WORD_WIDTH + 1);

    logic [WORD_WIDTH-1:0] rem_reg, quo_reg, den_reg;
    logic                  neg_reg, busy_reg, done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [WORD_WIDTH:0]   trial;

    // restoring divide, one quotient bit a cycle, on magnitudes
    assign trial = {rem_reg, quo_reg[WORD_WIDTH-1]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WORD_WIDTH);
                rem_reg  <= '0;
                quo_reg  <= dividend[WORD_WIDTH-1] ? (~dividend + 1'b1) : dividend;
                den_reg  <= divisor[WORD_WIDTH-1] ? (~divisor + 1'b1) : divisor;
                neg_reg  <= dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
            end else if (busy_reg) begin
                if (trial[WORD_WIDTH]) begin
                    rem_reg <= {rem_reg[WORD_WIDTH-2:0], quo_reg[WORD_WIDTH-1]};
                    quo_reg <= {quo_reg[WORD_WIDTH-2:0], 1'b0};
                end else begin
                    rem_reg <= trial[WORD_WIDTH-1:0];
                    quo_reg <= {quo_reg[WORD_WIDTH-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

@@ design/pcode_stack_machine_unit.sv @@
// p-code stack machine: each input beat is one instruction (op, level, operand);
// each output beat reports next pc, stack top word and index, fault and halt.
// the data stack lives in one single-port-write, registered-read memory, so an
// instruction is a short sequence of reads and writes: once accepted it passes
// ST_WALK, ST_RD1, ST_RD2, ST_EXEC, ST_TOPRD and ST_DONE, and the result beat is
// loaded from ST_DONE when the output register is free; each static link hop of
// LOD, STO and CAL adds a read then a check (ST_WALK, ST_WWAIT), CAL adds ST_WR2
// and ST_WR3 for the frame mark writes, and OPR div waits in ST_DIV for the serial
// divider (WORD_WIDTH steps plus the write back). one instruction is in flight at
// a time; the next is taken in the idle cycle after the result beat sits in the
// output register.
// after reset a clearing pass writes zero over every stack word, one word per
// cycle, before the first instruction is accepted.
module pcode_stack_machine_unit
    import psm_pkg::*;
#(
    parameter int STACK_DEPTH = 512,
    parameter int MAX_LEVEL   = 3,
    parameter int WORD_WIDTH  = 32,
    parameter int MAX_ADDRESS = 2047
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_op,
    input  logic [1:0]                   s_level,
    input  logic signed [15:0]           s_operand,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [$clog2(MAX_ADDRESS+1)-1:0] m_next_pc,
    output logic signed [WORD_WIDTH-1:0] m_top_value,
    output logic [$clog2(STACK_DEPTH)-1:0] m_top_index,
    output logic [1:0]                   m_fault,
    output logic                         m_halted
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(MAX_ADDRESS + 1);
    localparam int LW = $clog2(MAX_LEVEL + 1);
    // signed working width for index math
    localparam int XW = (AW > 16 ? AW : 16) + 3;

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b000000000001,
        ST_IDLE  = 12'b000000000010,
        ST_WALK  = 12'b000000000100,   // static link reads
        ST_WWAIT = 12'b000000001000,
        ST_RD1   = 12'b000000010000,   // first operand read issued
        ST_RD2   = 12'b000000100000,   // second operand read issued
        ST_EXEC  = 12'b000001000000,
        ST_DIV   = 12'b000010000000,
        ST_WR2   = 12'b000100000000,   // extra writes for CAL
        ST_WR3   = 12'b001000000000,
        ST_TOPRD = 12'b010000000000,
        ST_DONE  = 12'b100000000000
    } state_t;

    // ---------------- stack memory
    logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];
    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [WORD_WIDTH-1:0] wdata, rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // ---------------- architectural state
    state_t                state_reg;
    logic [PW-1:0]         pc_reg;
    logic [AW-1:0]         base_reg, top_reg;
    logic [AW:0]           clr_reg;
    logic [2:0]            op_reg;
    logic [LW-1:0]         hops_reg;
    logic [15:0]           arg_reg;
    logic [AW-1:0]         bs_reg;      // frame found by the walk
    logic [WORD_WIDTH-1:0] x_reg;
    logic                  out_valid_reg;
    logic [PW-1:0]         onp_reg;
    logic [WORD_WIDTH-1:0] otv_reg;
    logic [AW-1:0]         oti_reg;
    logic [1:0]            oflt_reg;
    // pending result of the step
    logic [PW-1:0]         np_reg;
    logic [AW-1:0]         nt_reg;
    logic [1:0]            flt_reg;
    // caller's frame base and return pc kept for the CAL frame mark
    logic [AW-1:0]         bs_prev_reg;
    logic [PW-1:0]         np_seq_reg;

    // derived values
    logic [PW-1:0]         seq_pc, target;
    logic signed [XW-1:0]  top_x, base_x, frame_x, arg_x, sum_x;
    logic [WORD_WIDTH-1:0] lit;
    logic [LW-1:0]         hops_in;

    assign seq_pc  = (pc_reg == PW'(MAX_ADDRESS)) ? '0 : pc_reg + 1'b1;
    assign target  = PW'({16'd0, arg_reg} % (MAX_ADDRESS + 1));
    assign top_x   = XW'({1'b0, top_reg});
    assign base_x  = XW'({1'b0, bs_reg});
    assign frame_x = XW'({1'b0, base_reg});
    assign arg_x   = XW'(signed'(arg_reg));
    assign sum_x   = base_x + arg_x;
    assign lit     = WORD_WIDTH'(signed'(arg_reg));
    assign hops_in = (s_level > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(s_level);

    function automatic logic in_rng(input logic signed [XW-1:0] v);
        return (v >= 0) && (v < XW'(STACK_DEPTH));
    endfunction

    // word used as an index
    function automatic logic word_ok(input logic [WORD_WIDTH-1:0] w);
        return !w[WORD_WIDTH-1] && ({1'b0, w} < (WORD_WIDTH+1)'(STACK_DEPTH));
    endfunction

    function automatic logic lts(input logic [WORD_WIDTH-1:0] a,
                                 input logic [WORD_WIDTH-1:0] b);
        return signed'(a) < signed'(b);
    endfunction

    function automatic logic s_op_needs_walk(input logic [2:0] o);
        return o == OP_LOD || o == OP_STO || o == OP_CAL;
    endfunction

    // binary opr result
    function automatic logic [WORD_WIDTH-1:0] rexec(input logic [15:0] c,
            input logic [WORD_WIDTH-1:0] a, input logic [WORD_WIDTH-1:0] b);
        logic [WORD_WIDTH-1:0] v;
        case (c)
            OPR_ADD: v = a + b;
            OPR_SUB: v = a - b;
            OPR_MUL: v = a * b;
            OPR_EQL: v = WORD_WIDTH'(a == b);
            OPR_NEQ: v = WORD_WIDTH'(a != b);
            OPR_LSS: v = WORD_WIDTH'(lts(a, b));
            OPR_GEQ: v = WORD_WIDTH'(!lts(a, b));
            OPR_GTR: v = WORD_WIDTH'(lts(b, a));
            OPR_LEQ: v = WORD_WIDTH'(!lts(b, a));
            default: v = '0;
        endcase
        return v;
    endfunction

    // ---------------- divider
    div_ctl_t              dctl;
    div_sts_t              dsts;
    logic [WORD_WIDTH-1:0] quo;

    // divisor is the top word, on the read port while in exec
    psm_divider #(.WORD_WIDTH(WORD_WIDTH)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dctl),
        .dividend (x_reg),
        .divisor  (rdata_reg),
        .sts      (dsts),
        .quotient (quo)
    );

    // ---------------- sequencer
    logic                  accept;
    logic                  out_load;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= '0;
            base_reg      <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(STACK_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg   <= s_op;
                        arg_reg  <= s_operand;
                        hops_reg <= hops_in;
                        bs_reg   <= base_reg;
                        np_reg   <= seq_pc;
                        nt_reg   <= top_reg;
                        flt_reg  <= FAULT_NONE;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if ((s_op_needs_walk(op_reg)) && hops_reg != '0) begin
                        state_reg <= ST_WWAIT;   // read of bs issued
                    end else begin
                        state_reg <= ST_RD1;
                    end
                end
                ST_WWAIT: begin
                    if (!word_ok(rdata_reg)) begin
                        flt_reg   <= FAULT_RANGE;
                        state_reg <= ST_TOPRD;
                    end else begin
                        bs_reg    <= AW'(rdata_reg);
                        hops_reg  <= hops_reg - 1'b1;
                        state_reg <= ST_WALK;
                    end
                end
                ST_RD1: state_reg <= ST_RD2;
                ST_RD2: begin
                    x_reg     <= rdata_reg;
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    // divide runs on, CAL writes the rest of its frame mark
                    if (dctl.start) begin
                        state_reg <= ST_DIV;
                    end else if (op_reg == OP_CAL && in_rng(XW'(top_x + 3))) begin
                        state_reg <= ST_WR2;
                    end else begin
                        state_reg <= ST_TOPRD;
                    end
                    case (op_reg)
                        OP_LIT: begin
                            if (!in_rng(XW'(top_x + 1))) flt_reg <= FAULT_RANGE;
                            else nt_reg <= top_reg + 1'b1;
                        end
                        OP_OPR: begin
                            if (arg_reg == OPR_RET) begin
                                if (!in_rng(XW'(frame_x - 1))
                                    || !in_rng(XW'(frame_x + 2))
                                    || !word_ok(x_reg)) begin
                                    flt_reg <= FAULT_RANGE;
                                end else begin
                                    nt_reg   <= base_reg - 1'b1;
                                    base_reg <= AW'(x_reg);
                                    np_reg   <= PW'({32'd0, rdata_reg} % (MAX_ADDRESS + 1));
                                end
                            end else if (arg_reg == OPR_NEG || arg_reg == OPR_ODD) begin
                                // written below
                            end else if (arg_reg <= OPR_LEQ) begin
                                if (top_reg == '0) flt_reg <= FAULT_RANGE;
                                else begin
                                    nt_reg <= top_reg - 1'b1;
                                    if (arg_reg == OPR_DIV && rdata_reg == '0) begin
                                        flt_reg <= FAULT_DIV0;
                                    end
                                end
                            end
                        end
                        OP_LOD: begin
                            if (!in_rng(sum_x) || !in_rng(XW'(top_x + 1)))
                                flt_reg <= FAULT_RANGE;
                            else nt_reg <= top_reg + 1'b1;
                        end
                        OP_STO: begin
                            if (top_reg == '0 || !in_rng(sum_x)) flt_reg <= FAULT_RANGE;
                            else nt_reg <= top_reg - 1'b1;
                        end
                        OP_CAL: begin
                            if (!in_rng(XW'(top_x + 3))) flt_reg <= FAULT_RANGE;
                            else begin
                                base_reg  <= top_reg + 1'b1;
                                np_reg    <= target;
                            end
                        end
                        OP_INT: begin
                            if (!in_rng(top_x + arg_x)) flt_reg <= FAULT_RANGE;
                            else nt_reg <= AW'(top_x + arg_x);
                        end
                        OP_JMP: np_reg <= target;
                        default: begin
                            if (top_reg == '0) flt_reg <= FAULT_RANGE;
                            else begin
                                nt_reg <= top_reg - 1'b1;
                                if (rdata_reg == '0) np_reg <= target;
                            end
                        end
                    endcase
                end
                ST_DIV: begin
                    if (dsts.done) state_reg <= ST_TOPRD;
                end
                ST_WR2: state_reg <= ST_WR3;
                ST_WR3: state_reg <= ST_TOPRD;
                ST_TOPRD: begin
                    if (flt_reg == FAULT_RANGE) begin
                        np_reg <= seq_pc;
                        nt_reg <= top_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        pc_reg        <= np_reg;
                        top_reg       <= nt_reg;
                        onp_reg       <= np_reg;
                        otv_reg       <= rdata_reg;
                        oti_reg       <= nt_reg;
                        oflt_reg      <= flt_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // memory port control
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = top_reg;
        case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = AW'(clr_reg);
            end
            ST_WALK:  raddr = bs_reg;
            ST_RD1: begin
                // x operand
                if (op_reg == OP_OPR && arg_reg == OPR_RET) raddr = base_reg + 1'b1;
                else if (op_reg == OP_LOD) raddr = AW'(sum_x);
                else raddr = top_reg - 1'b1;
            end
            ST_RD2: begin
                if (op_reg == OP_OPR && arg_reg == OPR_RET) raddr = base_reg + 2'd2;
                else raddr = top_reg;
            end
            ST_EXEC: begin
                if (op_reg == OP_OPR) begin
                    if (arg_reg == OPR_NEG) begin
                        we = 1'b1; waddr = top_reg; wdata = '0 - rdata_reg;
                    end else if (arg_reg == OPR_ODD) begin
                        we = 1'b1; waddr = top_reg; wdata = WORD_WIDTH'(rdata_reg[0]);
                    end else if (arg_reg != OPR_RET && arg_reg != OPR_DIV
                                 && arg_reg <= OPR_LEQ && top_reg != '0) begin
                        we = 1'b1; waddr = top_reg - 1'b1;
                        wdata = rexec(arg_reg, x_reg, rdata_reg);
                    end else if (arg_reg == OPR_DIV && top_reg != '0 && rdata_reg == '0) begin
                        we = 1'b1; waddr = top_reg - 1'b1; wdata = '0;
                    end
                end else if (op_reg == OP_LIT && in_rng(XW'(top_x + 1))) begin
                    we = 1'b1; waddr = top_reg + 1'b1; wdata = lit;
                end else if (op_reg == OP_LOD && in_rng(sum_x)
                             && in_rng(XW'(top_x + 1))) begin
                    we = 1'b1; waddr = top_reg + 1'b1; wdata = x_reg;
                end else if (op_reg == OP_STO && top_reg != '0 && in_rng(sum_x)) begin
                    we = 1'b1; waddr = AW'(sum_x); wdata = rdata_reg;
                end else if (op_reg == OP_CAL && in_rng(XW'(top_x + 3))) begin
                    we = 1'b1; waddr = top_reg + 1'b1; wdata = WORD_WIDTH'(bs_reg);
                end
            end
            ST_DIV: begin
                if (dsts.done) begin
                    we = 1'b1; waddr = top_reg - 1'b1; wdata = quo;
                end
            end
            ST_WR2: begin
                we = 1'b1; waddr = top_reg + 2'd2; wdata = WORD_WIDTH'(bs_prev_reg);
            end
            ST_WR3: begin
                we = 1'b1; waddr = top_reg + 2'd3; wdata = WORD_WIDTH'(np_seq_reg);
            end
            ST_TOPRD: raddr = (flt_reg == FAULT_RANGE) ? top_reg : nt_reg;
            ST_DONE:  raddr = nt_reg;
            default:  raddr = top_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            bs_prev_reg <= base_reg;
            np_seq_reg  <= seq_pc;
        end
    end

    assign dctl.start = (state_reg == ST_EXEC) && (op_reg == OP_OPR)
                        && (arg_reg == OPR_DIV) && (top_reg != '0) && (rdata_reg != '0);

    assign m_valid     = out_valid_reg;
    assign m_next_pc   = onp_reg;
    assign m_top_value = otv_reg;
    assign m_top_index = oti_reg;
    assign m_fault     = oflt_reg;
    assign m_halted    = (onp_reg == '0);

    // no beat taken while clearing
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("input taken during clear");
    // result register holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(onp_reg))
        else $error("result dropped");
    // a range fault leaves the top unchanged
    a_fault_top: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && flt_reg == FAULT_RANGE |-> nt_reg == top_reg)
        else $error("range fault moved top");
    // divider only runs in its state
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        dsts.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside divide");

endmodule

@@ tb/testbench.sv @@
module testbench
    import psm_pkg::*;
();

    localparam int DEPTH    = 512;
    localparam int ADDR_MOD = 2048;
    // clearing pass after reset plus slowest step and longest stall, several times over
    localparam int STALL_LIMIT = 4000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_op = '0;
    logic [1:0]         s_level = '0;
    logic signed [15:0] s_operand = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [10:0]        m_next_pc;
    logic signed [31:0] m_top_value;
    logic [8:0]         m_top_index;
    logic [1:0]         m_fault;
    logic               m_halted;

    // one expected result beat
    typedef struct {
        logic [10:0] next_pc;
        logic [31:0] top_value;
        logic [8:0]  top_index;
        logic [1:0]  fault;
        logic        halted;
    } step_result_t;

    // shadow machine state
    logic [31:0] shadow_stack [DEPTH];
    logic [10:0] shadow_pc;
    logic [8:0]  shadow_base;
    logic [8:0]  shadow_top;

    step_result_t pending_results[$];
    int  mismatches = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  idle_cycles = 0;
    int  fault_count = 0;
    bit  no_stall = 1'b0;

    pcode_stack_machine_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // a stack word read as an index: non-negative and inside the stack
    function automatic bit word_as_index(logic [31:0] w, output logic [8:0] idx);
        idx = w[8:0];
        return !w[31] && w < DEPTH;
    endfunction

    function automatic bit follow_links(logic [1:0] hops, output logic [8:0] base);
        logic [8:0] b;
        b = shadow_base;
        for (int i = 0; i < hops; i++)
            if (!word_as_index(shadow_stack[b], b)) return 1'b0;
        base = b;
        return 1'b1;
    endfunction

    // execute one instruction on the shadow machine and return its result beat
    function automatic step_result_t execute_instr(logic [2:0] op, logic [1:0] lv,
                                                   logic [15:0] arg);
        step_result_t r;
        logic [31:0] lit, x, y, q;
        logic [10:0] seq_pc, np;
        logic [8:0]  nb, bs, idx;
        int          t, nt, addr;
        logic [1:0]  flt;
        bit          bad;
        lit = {{16{arg[15]}}, arg};
        seq_pc = (shadow_pc == 11'(ADDR_MOD - 1)) ? 11'd0 : shadow_pc + 11'd1;
        np = seq_pc;
        nb = shadow_base;
        t = shadow_top;
        nt = t;
        flt = FAULT_NONE;
        bad = 1'b0;
        case (opcode_t'(op))
            OP_LIT: begin
                nt = t + 1;
                if (nt >= DEPTH) bad = 1'b1;
                else shadow_stack[nt] = lit;
            end
            OP_OPR: begin
                if (arg == OPR_RET) begin
                    nt = int'(shadow_base) - 1;
                    if (nt < 0 || nt + 3 >= DEPTH || !word_as_index(shadow_stack[nt + 2], idx))
                        bad = 1'b1;
                    else begin
                        nb = idx;
                        np = shadow_stack[nt + 3][10:0];
                    end
                end else if (arg == OPR_NEG) begin
                    shadow_stack[t] = -shadow_stack[t];
                end else if (arg == OPR_ODD) begin
                    shadow_stack[t] = {31'd0, shadow_stack[t][0]};
                end else if (arg <= OPR_LEQ) begin
                    if (t < 1) bad = 1'b1;
                    else begin
                        x = shadow_stack[t - 1];
                        y = shadow_stack[t];
                        q = '0;
                        case (arg)
                            OPR_ADD: q = x + y;
                            OPR_SUB: q = x - y;
                            OPR_MUL: q = x * y;
                            OPR_DIV: begin
                                if (y == 0) flt = FAULT_DIV0;
                                else if (x == 32'h8000_0000 && y == '1) q = x;
                                else q = $signed(x) / $signed(y);
                            end
                            OPR_EQL: q = 32'(x == y);
                            OPR_NEQ: q = 32'(x != y);
                            OPR_LSS: q = 32'($signed(x) < $signed(y));
                            OPR_GEQ: q = 32'($signed(x) >= $signed(y));
                            OPR_GTR: q = 32'($signed(x) > $signed(y));
                            default: q = 32'($signed(x) <= $signed(y));
                        endcase
                        shadow_stack[t - 1] = q;
                        nt = t - 1;
                    end
                end
            end
            OP_LOD: begin
                nt = t + 1;
                if (!follow_links(lv, bs)) bad = 1'b1;
                else begin
                    addr = int'(bs) + $signed(arg);
                    if (addr < 0 || addr >= DEPTH || nt >= DEPTH) bad = 1'b1;
                    else shadow_stack[nt] = shadow_stack[addr];
                end
            end
            OP_STO: begin
                if (t < 1 || !follow_links(lv, bs)) bad = 1'b1;
                else begin
                    addr = int'(bs) + $signed(arg);
                    if (addr < 0 || addr >= DEPTH) bad = 1'b1;
                    else begin
                        shadow_stack[addr] = shadow_stack[t];
                        nt = t - 1;
                    end
                end
            end
            OP_CAL: begin
                if (!follow_links(lv, bs) || t + 3 >= DEPTH) bad = 1'b1;
                else begin
                    shadow_stack[t + 1] = {23'd0, bs};
                    shadow_stack[t + 2] = {23'd0, shadow_base};
                    shadow_stack[t + 3] = {21'd0, seq_pc};
                    nb = 9'(t + 1);
                    np = arg[10:0];
                end
            end
            OP_INT: begin
                nt = t + $signed(arg);
                if (nt < 0 || nt >= DEPTH) bad = 1'b1;
            end
            OP_JMP: np = arg[10:0];
            default: begin
                if (t < 1) bad = 1'b1;
                else begin
                    if (shadow_stack[t] == 0) np = arg[10:0];
                    nt = t - 1;
                end
            end
        endcase
        if (bad) begin
            flt = FAULT_RANGE;
            np = seq_pc;
            nt = t;
            nb = shadow_base;
        end
        shadow_pc = np;
        shadow_base = nb;
        shadow_top = 9'(nt);
        r.next_pc = np;
        r.top_value = shadow_stack[shadow_top];
        r.top_index = shadow_top;
        r.fault = flt;
        r.halted = (np == 0);
        return r;
    endfunction

    // send one instruction beat after a random gap; valid stays up when there is none
    task automatic send_instr(opcode_t op, logic [1:0] lv, logic [15:0] arg);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_level <= lv;
        s_operand <= arg;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(execute_instr(op, lv, arg));
        beats_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // result side: random stalls, compare each beat with the oldest expectation
    initial begin
        step_result_t exp_r;
        int stall;
        forever begin
            stall = no_stall ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats_checked++;
            if (m_fault != FAULT_NONE) fault_count++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat pc=%0d", m_next_pc);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_next_pc !== exp_r.next_pc || m_top_value !== exp_r.top_value ||
                    m_top_index !== exp_r.top_index || m_fault !== exp_r.fault ||
                    m_halted !== exp_r.halted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp pc=%0d val=%0h idx=%0d flt=%0d h=%0d,",
                                  " got pc=%0d val=%0h idx=%0d flt=%0d h=%0d"},
                                 exp_r.next_pc, exp_r.top_value, exp_r.top_index,
                                 exp_r.fault, exp_r.halted, m_next_pc, m_top_value,
                                 m_top_index, m_fault, m_halted);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // extremes, pops from an empty stack, every op and every OPR code
    task automatic test_directed();
        send_instr(OP_OPR, 2'd0, OPR_ADD);
        send_instr(OP_JPC, 2'd0, 16'd5);
        send_instr(OP_OPR, 2'd0, OPR_RET);
        send_instr(OP_LIT, 2'd0, 16'h7fff);
        send_instr(OP_LIT, 2'd3, 16'h8000);
        for (logic [15:0] c = OPR_NEG; c <= 16'd13; c++) begin
            send_instr(OP_LIT, 2'd0, 16'($urandom));
            send_instr(OP_OPR, 2'd0, c);
        end
        send_instr(OP_LIT, 2'd0, 16'd0);
        send_instr(OP_OPR, 2'd0, OPR_DIV);
        send_instr(OP_INT, 2'd0, 16'h7fff);
        send_instr(OP_INT, 2'd0, 16'h8000);
        send_instr(OP_LOD, 2'd3, 16'hffff);
        send_instr(OP_STO, 2'd0, 16'd1);
        send_instr(OP_CAL, 2'd0, 16'hffff);
        send_instr(OP_OPR, 2'd0, OPR_RET);
        send_instr(OP_JMP, 2'd0, 16'd0);
        send_instr(OP_INT, 2'd0, 16'd511);
        send_instr(OP_LIT, 2'd0, 16'd1);
        send_instr(OP_CAL, 2'd0, 16'd3);
        send_instr(OP_INT, 2'd0, -16'sd511);
    endtask

    // mostly well-formed procedure bodies with random contents, some noise
    task automatic test_random_programs(int count);
        int    sel;
        logic [15:0] arg;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (shadow_top > 9'd400) send_instr(OP_INT, 2'd0, -16'sd300);
            else if (sel < 10) send_instr(OP_LIT, 2'($urandom), 16'($urandom));
            else if (sel < 20) send_instr(OP_LIT, 2'd0, 16'($urandom_range(0, 8)) - 16'd4);
            else if (sel < 40) send_instr(OP_OPR, 2'($urandom), 16'($urandom_range(1, 14)));
            else if (sel < 52) send_instr(OP_LOD, 2'($urandom), 16'($urandom_range(0, 6)));
            else if (sel < 62) send_instr(OP_STO, 2'($urandom), 16'($urandom_range(0, 6)));
            else if (sel < 70) send_instr(OP_CAL, 2'($urandom), 16'($urandom));
            else if (sel < 78) send_instr(OP_OPR, 2'd0, OPR_RET);
            else if (sel < 86) send_instr(OP_INT, 2'd0, 16'($urandom_range(0, 8)) - 16'd2);
            else if (sel < 92) send_instr(OP_JMP, 2'($urandom), 16'($urandom));
            else if (sel < 97) send_instr(OP_JPC, 2'($urandom), 16'($urandom));
            else begin
                arg = 16'($urandom);
                send_instr(opcode_t'(3'($urandom_range(0, 7))), 2'($urandom), arg);
            end
        end
    endtask

    // back-to-back traffic after a full drain
    task automatic test_no_stall();
        wait_drained();
        no_stall = 1'b1;
        test_random_programs(150);
        wait_drained();
        no_stall = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) shadow_stack[i] = '0;
        shadow_pc = '0;
        shadow_base = '0;
        shadow_top = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_programs(450);
        test_no_stall();
        test_random_programs(400);
        wait_drained();
        repeat (60) @(posedge aclk);
        $display("ran %0d instructions, %0d results checked, %0d faulting steps",
                 beats_sent, beats_checked, fault_count);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/psm_pkg.sv
design/psm_divider.sv
design/pcode_stack_machine_unit.sv
tb/testbench.sv
